// ===== rtl/spcp_pkg.sv =====
// ----------------------------------------------------------------------------
// spcp_pkg
// Shared types and constants of the signed pair command parser.
// ----------------------------------------------------------------------------
package spcp_pkg;

  // Pairs that one text may deliver before further pairs are dropped.
  localparam logic [3:0] PAIR_CAPACITY = 4'd15;

  // Largest magnitude the digit accumulator holds; it saturates there.
  localparam logic [9:0] ACC_MAX = 10'd1023;

  localparam logic [7:0] CHAR_L     = 8'h6C;
  localparam logic [7:0] CHAR_R     = 8'h72;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [6:0] DEADBAND_RESET = 7'd30;
  localparam logic [6:0] BOOST_RESET    = 7'd40;
  localparam logic [6:0] RANGE_RESET    = 7'd100;

  typedef enum logic [1:0] {
    CFG_DEADBAND = 2'd0,
    CFG_BOOST    = 2'd1,
    CFG_RANGE    = 2'd2
  } cfg_index_e;

  typedef enum logic [2:0] {
    PH_SEEK_L = 3'd0,
    PH_L_LEAD = 3'd1,
    PH_L_BODY = 3'd2,
    PH_SEEK_R = 3'd3,
    PH_R_LEAD = 3'd4,
    PH_R_BODY = 3'd5
  } phase_e;

  typedef struct packed {
    logic [6:0] deadband_limit;
    logic [6:0] boost_amount;
    logic [6:0] range_limit;
  } cfg_t;

  // State of the number being read.
  typedef struct packed {
    logic       negative;
    logic       digit_seen;
    logic [9:0] magnitude;
  } number_t;

endpackage

// ===== rtl/signed_pair_command_parser.sv =====
// ----------------------------------------------------------------------------
// signed_pair_command_parser
// Byte-wise parser for 'l' <number> ... 'r' <number> pair commands.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while no stall holds it, and each byte
// passes through an input register, then one
// pass of parser update (digit accumulate, number close, marker match, pair
// count) into the result register. A result is produced for every accepted
// pair and for the byte flagged end_of_text; other bytes produce none. The
// input register keeps taking a byte while a result waits to be taken, and
// input stalls only when a second result is due behind it. Configuration
// registers should be written while no text is in flight.
// ----------------------------------------------------------------------------
module signed_pair_command_parser import spcp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [6:0]        cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        char_in_i,
  input  logic              end_of_text_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic signed [7:0] left_value_o,
  output logic signed [7:0] right_value_o,
  output logic              pair_valid_o,
  output logic [3:0]        pair_number_o,
  output logic              text_done_o,
  output logic              capacity_overflow_o
);

  cfg_t cfg_q;

  logic       in_valid_q;
  logic [7:0] char_q;
  logic       eot_q;

  phase_e            phase_q, phase_d, phase_b;
  number_t           num_q, num_d, num_b;
  logic signed [7:0] held_q, held_d, held_b;
  logic [3:0]        pairs_q, pairs_d;
  logic              ovf_q, ovf_d;

  logic              out_valid_q;
  logic signed [7:0] left_q, right_q;
  logic              pvalid_q, done_q, oflow_q;
  logic [3:0]        pnum_q;

  logic signed [7:0] val_cur, val_fin;
  logic              ok_cur, ok_fin;

  logic        is_digit, is_ws, is_sign, is_lead, is_left;
  logic [13:0] acc_ext;
  logic [9:0]  acc_sat;
  logic        take_req, fin_req, pair_req, pair_ok, hit, emit;
  logic signed [7:0] pair_right;
  logic        out_free, proc;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deadband_limit <= DEADBAND_RESET;
      cfg_q.boost_amount   <= BOOST_RESET;
      cfg_q.range_limit    <= RANGE_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DEADBAND: cfg_q.deadband_limit <= cfg_data_i;
        CFG_BOOST:    cfg_q.boost_amount   <= cfg_data_i;
        CFG_RANGE:    cfg_q.range_limit    <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // Handshake: the parser advances unless it owes a result that cannot be
  // stored because the result register is still full.
  assign out_free   = !out_valid_q || out_ready_i;
  assign proc       = in_valid_q && (!emit || out_free);
  assign in_ready_o = !in_valid_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      char_q <= char_in_i;
      eot_q  <= end_of_text_i;
    end
  end

  // Byte classification and digit accumulation.
  assign is_digit = (char_q >= CHAR_ZERO) && (char_q <= CHAR_NINE);
  assign is_ws    = (char_q == CHAR_SPACE) || ((char_q >= CHAR_TAB) && (char_q <= CHAR_CR));
  assign is_sign  = (char_q == CHAR_PLUS) || (char_q == CHAR_MINUS);
  assign is_lead  = (phase_q == PH_L_LEAD) || (phase_q == PH_R_LEAD);
  assign is_left  = (phase_q == PH_L_LEAD) || (phase_q == PH_L_BODY);
  assign acc_ext  = ({4'd0, num_q.magnitude} << 3) + ({4'd0, num_q.magnitude} << 1)
                  + {10'd0, char_q[3:0]};
  assign acc_sat  = (acc_ext > {4'd0, ACC_MAX}) ? ACC_MAX : acc_ext[9:0];

  spcp_finish u_finish_cur (
    .number_i   (num_q),
    .cfg_i      (cfg_q),
    .value_o    (val_cur),
    .in_range_o (ok_cur)
  );

  // The byte itself: number continuation, number close, then marker match.
  always_comb begin
    logic check_marker;
    phase_b      = phase_q;
    num_b        = num_q;
    held_b       = held_q;
    take_req     = 1'b0;
    check_marker = 1'b1;
    unique case (phase_q)
      PH_L_LEAD, PH_L_BODY, PH_R_LEAD, PH_R_BODY: begin
        if (is_digit) begin
          num_b.magnitude  = acc_sat;
          num_b.digit_seen = 1'b1;
          phase_b          = is_left ? PH_L_BODY : PH_R_BODY;
          check_marker     = 1'b0;
        end else if (is_lead && is_ws) begin
          check_marker = 1'b0;
        end else if (is_lead && is_sign) begin
          num_b.negative = (char_q == CHAR_MINUS);
          phase_b        = is_left ? PH_L_BODY : PH_R_BODY;
          check_marker   = 1'b0;
        end else if (is_left) begin
          if (ok_cur) begin
            held_b  = val_cur;
            phase_b = PH_SEEK_R;
          end else begin
            phase_b = PH_SEEK_L;
          end
        end else begin
          take_req = 1'b1;
          phase_b  = PH_SEEK_L;
        end
      end
      PH_SEEK_R: phase_b = PH_SEEK_R;
      default:   phase_b = PH_SEEK_L;
    endcase
    if (check_marker) begin
      if ((phase_b == PH_SEEK_L) && (char_q == CHAR_L)) begin
        phase_b = PH_L_LEAD;
        num_b   = '0;
      end else if ((phase_b == PH_SEEK_R) && (char_q == CHAR_R)) begin
        phase_b = PH_R_LEAD;
        num_b   = '0;
      end
    end
  end

  spcp_finish u_finish_end (
    .number_i   (num_b),
    .cfg_i      (cfg_q),
    .value_o    (val_fin),
    .in_range_o (ok_fin)
  );

  // End of text closes a pending right number; at most one pair completes.
  assign fin_req    = eot_q && ((phase_b == PH_R_LEAD) || (phase_b == PH_R_BODY));
  assign pair_req   = take_req || fin_req;
  assign pair_ok    = fin_req ? ok_fin : ok_cur;
  assign pair_right = fin_req ? val_fin : val_cur;
  assign hit        = pair_req && pair_ok && (pairs_q < PAIR_CAPACITY);
  assign emit       = hit || eot_q;

  always_comb begin
    if (eot_q) begin
      phase_d = PH_SEEK_L;
      num_d   = '0;
      held_d  = '0;
      pairs_d = '0;
      ovf_d   = 1'b0;
    end else begin
      phase_d = phase_b;
      num_d   = num_b;
      held_d  = held_b;
      pairs_d = pairs_q + {3'd0, hit};
      ovf_d   = ovf_q || (pair_req && pair_ok && !hit);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEEK_L;
      num_q   <= '0;
      held_q  <= '0;
      pairs_q <= '0;
      ovf_q   <= 1'b0;
    end else if (proc) begin
      phase_q <= phase_d;
      num_q   <= num_d;
      held_q  <= held_d;
      pairs_q <= pairs_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && emit) begin
      left_q   <= hit ? held_b : 8'sd0;
      right_q  <= hit ? pair_right : 8'sd0;
      pvalid_q <= hit;
      pnum_q   <= eot_q ? (pairs_q + {3'd0, hit}) : pairs_q;
      done_q   <= eot_q;
      oflow_q  <= ovf_q || (pair_req && pair_ok && !hit);
    end
  end

  assign out_valid_o         = out_valid_q;
  assign left_value_o        = left_q;
  assign right_value_o       = right_q;
  assign pair_valid_o        = pvalid_q;
  assign pair_number_o       = pnum_q;
  assign text_done_o         = done_q;
  assign capacity_overflow_o = oflow_q;

endmodule

// ===== rtl/spcp_finish.sv =====
// ----------------------------------------------------------------------------
// spcp_finish
// Closes a parsed number: applies the deadband boost, the sign and the range
// check.
// ----------------------------------------------------------------------------
module spcp_finish import spcp_pkg::*; (
  input  number_t           number_i,
  input  cfg_t              cfg_i,
  output logic signed [7:0] value_o,
  output logic              in_range_o
);

  logic [9:0]  mag_raw;
  logic [10:0] mag;

  always_comb begin
    mag_raw = number_i.digit_seen ? number_i.magnitude : 10'd0;
    if ((mag_raw != 10'd0) && (mag_raw < {3'd0, cfg_i.deadband_limit})) begin
      mag = {1'b0, mag_raw} + {4'd0, cfg_i.boost_amount};
    end else begin
      mag = {1'b0, mag_raw};
    end
  end

  // The value is only used when it is in range, so eight bits carry it whole.
  assign value_o    = number_i.negative ? -$signed(mag[7:0]) : $signed(mag[7:0]);
  assign in_range_o = (mag <= {4'd0, cfg_i.range_limit});

endmodule
